// ----- design/ppp_pkg.sv -----
// shared widths, codes, types and helpers for the polyline projection block
`timescale 1ns / 1ps
package ppp_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int OPER_W      = COORD_WIDTH + 2;
    localparam int PROD_W      = 2 * OPER_W;
    localparam int VV_W        = 2 * COORD_WIDTH + 2;
    localparam int DOT_W       = VV_W + 1;
    localparam int ROOT_W      = VV_W / 2;
    localparam int T_W         = FRAC_BITS + 1;
    localparam int LEN_W       = 40;
    localparam int DSQ_W       = 64;
    localparam int IN_W        = 2 * COORD_WIDTH;
    localparam int OUT_W       = 2 * LEN_W;
    localparam int CFG_IDX_W   = 1;

    localparam logic [LEN_W-1:0] LEN_MAX = '1;
    localparam logic [T_W-1:0]   T_ONE   = T_W'(1) << FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_Y = 1'b1;

    // multiplier operand selection
    typedef enum logic [3:0] {
        M_NONE,
        M_VXVX,
        M_VYVY,
        M_UXVX,
        M_UYVY,
        M_AVXT,
        M_AVYT,
        M_DXDX,
        M_DYDY,
        M_TSEG
    } t_mop;

    // datapath register action
    typedef enum logic [3:0] {
        A_NONE,
        A_LOAD,
        A_ACC,
        A_VVSUM,
        A_DOTSUM,
        A_TSEL,
        A_TDIV,
        A_PX,
        A_PY,
        A_DY,
        A_DSUM,
        A_UPD,
        A_STEP,
        A_EMIT
    } t_act;

    typedef struct packed {
        t_mop mop;
        t_act act;
        logic sqrt_go;
    } t_cmd;

    typedef struct packed {
        logic seen_any;
        logic last;
        logic div_need;
        logic div_busy;
        logic sqrt_busy;
    } t_sts;

    function automatic logic [LEN_W-1:0] sat_len(input logic [PROD_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (v[PROD_W-1:LEN_W] != '0) r = LEN_MAX;
        else r = v[LEN_W-1:0];
        return r;
    endfunction

endpackage

// ----- design/ppp_div.sv -----
// restoring divider for the projection parameter, one quotient bit per cycle
`timescale 1ns / 1ps
module ppp_div import ppp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [VV_W-1:0]      i_dividend,
    input  logic [VV_W-1:0]      i_divisor,
    output logic                 o_busy,
    output logic [FRAC_BITS-1:0] o_quot
);
    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic                 r_busy, n_busy;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [VV_W-1:0]      r_rem, n_rem;
    logic [VV_W-1:0]      r_div, n_div;
    logic [FRAC_BITS-1:0] r_quot, n_quot;
    logic [VV_W:0]        w_sh;
    logic                 w_ge;

    assign w_sh = {r_rem, 1'b0};
    assign w_ge = w_sh >= {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_div  = r_div;
        n_quot = r_quot;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(FRAC_BITS);
            n_rem  = i_dividend;
            n_div  = i_divisor;
            n_quot = '0;
        end else if (r_busy) begin
            // remainder stays below the divisor, so its top bit is dropped safely
            n_rem  = w_ge ? VV_W'(w_sh - {1'b0, r_div}) : w_sh[VV_W-1:0];
            n_quot = {r_quot[FRAC_BITS-2:0], w_ge};
            n_cnt  = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_quot <= n_quot;
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
endmodule

// ----- design/ppp_sqrt.sv -----
// digit-by-digit integer square root, two radicand bits per cycle
`timescale 1ns / 1ps
module ppp_sqrt import ppp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [VV_W-1:0]   i_rad,
    output logic              o_busy,
    output logic [ROOT_W-1:0] o_root
);
    localparam int CNT_W = $clog2(ROOT_W + 1);
    localparam int REM_W = ROOT_W + 3;

    logic              r_busy, n_busy;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [VV_W-1:0]   r_rad, n_rad;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [REM_W-1:0]  w_cur, w_trial;
    logic              w_ge;

    assign w_cur   = {r_rem[REM_W-3:0], r_rad[VV_W-1:VV_W-2]};
    assign w_trial = REM_W'({r_root, 2'b01});
    assign w_ge    = w_cur >= w_trial;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(ROOT_W);
            n_rad  = i_rad;
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            n_rem  = w_ge ? w_cur - w_trial : w_cur;
            n_root = {r_root[ROOT_W-2:0], w_ge};
            n_rad  = {r_rad[VV_W-3:0], 2'b00};
            n_cnt  = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_busy = r_busy;
    assign o_root = r_root;
endmodule

// ----- design/ppp_dp.sv -----
// datapath: robot registers, path state, shared multiplier, divider and root units
`timescale 1ns / 1ps
module ppp_dp import ppp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [COORD_WIDTH-1:0] i_cfg_data,
    input  logic [COORD_WIDTH-1:0] i_vertex_x,
    input  logic [COORD_WIDTH-1:0] i_vertex_y,
    input  logic                   i_last_vertex,
    output logic                   o_valid_res,
    output logic [LEN_W-1:0]       o_progress_length,
    output logic [LEN_W-1:0]       o_remaining_length
);
    logic signed [COORD_WIDTH-1:0] r_robot_x, r_robot_y;
    logic signed [COORD_WIDTH-1:0] r_prev_x, r_prev_y, r_bx, r_by;
    logic [1:0]                    r_seen;
    logic [LEN_W-1:0]              r_total, r_best_prog;
    logic [DSQ_W-1:0]              r_best_dsq, r_dsq;
    logic                          r_last;
    logic signed [DIFF_W-1:0]      r_vx, r_vy, r_ux, r_uy;
    logic signed [PROD_W-1:0]      r_prod, r_acc;
    logic [VV_W-1:0]               r_vv;
    logic signed [DOT_W-1:0]       r_dot;
    logic [T_W-1:0]                r_t;
    logic signed [OPER_W-1:0]      r_px, r_py, r_dx, r_dy;
    logic                          r_valid_res;
    logic [LEN_W-1:0]              r_prog_out, r_rem_out;

    logic signed [COORD_WIDTH-1:0] w_in_x, w_in_y;
    logic signed [OPER_W-1:0]      w_a, w_b, w_avx, w_avy, w_t_op, w_seg_op;
    logic signed [OPER_W-1:0]      w_off;
    logic signed [PROD_W-1:0]      w_sum;
    logic                          w_vv_nz, w_dot_pos, w_dot_ge, w_div_go;
    logic                          w_div_busy, w_sqrt_busy;
    logic [FRAC_BITS-1:0]          w_quot;
    logic [ROOT_W-1:0]             w_root;
    logic [LEN_W-1:0]              w_seg, w_part, w_best_new, w_total_new;
    logic                          w_better;

    assign w_in_x = i_vertex_x;
    assign w_in_y = i_vertex_y;

    // multiplier operands
    assign w_avx    = r_vx[DIFF_W-1] ? -OPER_W'(r_vx) : OPER_W'(r_vx);
    assign w_avy    = r_vy[DIFF_W-1] ? -OPER_W'(r_vy) : OPER_W'(r_vy);
    assign w_t_op   = $signed({{(OPER_W-T_W){1'b0}}, r_t});
    assign w_seg_op = $signed({{(OPER_W-ROOT_W){1'b0}}, w_root});

    always_comb begin
        w_a = '0;
        w_b = '0;
        unique case (i_cmd.mop)
            M_NONE: begin
                w_a = '0;
                w_b = '0;
            end
            M_VXVX: begin
                w_a = OPER_W'(r_vx);
                w_b = OPER_W'(r_vx);
            end
            M_VYVY: begin
                w_a = OPER_W'(r_vy);
                w_b = OPER_W'(r_vy);
            end
            M_UXVX: begin
                w_a = OPER_W'(r_ux);
                w_b = OPER_W'(r_vx);
            end
            M_UYVY: begin
                w_a = OPER_W'(r_uy);
                w_b = OPER_W'(r_vy);
            end
            M_AVXT: begin
                w_a = w_avx;
                w_b = w_t_op;
            end
            M_AVYT: begin
                w_a = w_avy;
                w_b = w_t_op;
            end
            M_DXDX: begin
                w_a = r_dx;
                w_b = r_dx;
            end
            M_DYDY: begin
                w_a = r_dy;
                w_b = r_dy;
            end
            M_TSEG: begin
                w_a = w_t_op;
                w_b = w_seg_op;
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign w_sum     = r_acc + r_prod;
    assign w_vv_nz   = r_vv != '0;
    assign w_dot_pos = !r_dot[DOT_W-1] && (r_dot != '0);
    assign w_dot_ge  = $unsigned(r_dot) >= {1'b0, r_vv};
    assign w_div_go  = (i_cmd.act == A_TSEL) && w_vv_nz && w_dot_pos && !w_dot_ge;

    // projection offset is truncated toward zero, then signed like the segment
    assign w_off = $signed(r_prod[FRAC_BITS +: OPER_W]);

    assign w_seg       = sat_len(PROD_W'(w_root));
    assign w_part      = sat_len({{FRAC_BITS{1'b0}}, r_prod[PROD_W-1:FRAC_BITS]});
    assign w_best_new  = sat_len(PROD_W'(r_total) + PROD_W'(w_part));
    assign w_total_new = sat_len(PROD_W'(r_total) + PROD_W'(w_seg));
    assign w_better    = (r_seen == 2'd1) || (r_dsq < r_best_dsq);

    ppp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_go),
        .i_dividend (r_dot[VV_W-1:0]),
        .i_divisor  (r_vv),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot)
    );

    ppp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_go),
        .i_rad   (r_vv),
        .o_busy  (w_sqrt_busy),
        .o_root  (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_robot_x   <= '0;
            r_robot_y   <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_seen      <= '0;
            r_total     <= '0;
            r_best_dsq  <= '1;
            r_best_prog <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ROBOT_X: r_robot_x <= i_cfg_data;
                    CFG_ROBOT_Y: r_robot_y <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.act == A_UPD) begin
                if (w_better) begin
                    r_best_dsq  <= r_dsq;
                    r_best_prog <= w_best_new;
                end
                r_total <= w_total_new;
            end
            if (i_cmd.act == A_STEP) begin
                r_prev_x <= r_bx;
                r_prev_y <= r_by;
                if (r_seen != 2'd2) r_seen <= r_seen + 2'd1;
            end
            if (i_cmd.act == A_EMIT) begin
                r_prev_x    <= '0;
                r_prev_y    <= '0;
                r_seen      <= '0;
                r_total     <= '0;
                r_best_dsq  <= '1;
                r_best_prog <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_a * w_b;
        unique case (i_cmd.act)
            A_LOAD: begin
                r_bx   <= w_in_x;
                r_by   <= w_in_y;
                r_last <= i_last_vertex;
                r_vx   <= DIFF_W'(w_in_x) - DIFF_W'(r_prev_x);
                r_vy   <= DIFF_W'(w_in_y) - DIFF_W'(r_prev_y);
                r_ux   <= DIFF_W'(r_robot_x) - DIFF_W'(r_prev_x);
                r_uy   <= DIFF_W'(r_robot_y) - DIFF_W'(r_prev_y);
            end
            A_ACC:    r_acc <= r_prod;
            A_VVSUM:  r_vv  <= w_sum[VV_W-1:0];
            A_DOTSUM: r_dot <= w_sum[DOT_W-1:0];
            A_TSEL:   r_t   <= (w_vv_nz && w_dot_pos && w_dot_ge) ? T_ONE : '0;
            A_TDIV: begin
                if (!w_div_busy) r_t <= {1'b0, w_quot};
            end
            A_PX: r_px <= OPER_W'(r_prev_x) + (r_vx[DIFF_W-1] ? -w_off : w_off);
            A_PY: begin
                r_py <= OPER_W'(r_prev_y) + (r_vy[DIFF_W-1] ? -w_off : w_off);
                r_dx <= OPER_W'(r_robot_x) - r_px;
            end
            A_DY: r_dy <= OPER_W'(r_robot_y) - r_py;
            A_DSUM: begin
                // squared distance saturates to its word
                r_dsq <= (w_sum[PROD_W-1:DSQ_W] != '0) ? '1 : w_sum[DSQ_W-1:0];
            end
            A_EMIT: begin
                r_valid_res <= r_seen != 2'd0;
                r_prog_out  <= r_best_prog;
                r_rem_out   <= (r_best_prog <= r_total) ? r_total - r_best_prog : '0;
            end
            A_NONE, A_UPD, A_STEP: ;
            default: ;
        endcase
    end

    assign o_sts.seen_any  = r_seen != 2'd0;
    assign o_sts.last      = r_last;
    assign o_sts.div_need  = w_vv_nz && w_dot_pos && !w_dot_ge;
    assign o_sts.div_busy  = w_div_busy;
    assign o_sts.sqrt_busy = w_sqrt_busy;

    assign o_valid_res        = r_valid_res;
    assign o_progress_length  = r_prog_out;
    assign o_remaining_length = r_rem_out;
endmodule

// ----- design/ppp_ctrl.sv -----
// controller: sequences one segment through the shared datapath units
`timescale 1ns / 1ps
module ppp_ctrl import ppp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [16:0] {
        S_IDLE = 17'b1 << 0,
        S_VV0  = 17'b1 << 1,
        S_VV1  = 17'b1 << 2,
        S_UV0  = 17'b1 << 3,
        S_UV1  = 17'b1 << 4,
        S_DOT  = 17'b1 << 5,
        S_TSEL = 17'b1 << 6,
        S_DIV  = 17'b1 << 7,
        S_OX   = 17'b1 << 8,
        S_OY   = 17'b1 << 9,
        S_PY   = 17'b1 << 10,
        S_DX   = 17'b1 << 11,
        S_DY   = 17'b1 << 12,
        S_DSUM = 17'b1 << 13,
        S_SQW  = 17'b1 << 14,
        S_UPD  = 17'b1 << 15,
        S_FIN  = 17'b1 << 16
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept, w_emit;

    assign w_accept = (r_state == S_IDLE) && i_in_valid;
    assign w_emit   = (r_state == S_FIN) && i_sts.last && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state       = r_state;
        o_cmd.mop     = M_NONE;
        o_cmd.act     = A_NONE;
        o_cmd.sqrt_go = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.act = A_LOAD;
                    n_state   = i_sts.seen_any ? S_VV0 : S_FIN;
                end
            end
            S_VV0: begin
                o_cmd.mop = M_VXVX;
                n_state   = S_VV1;
            end
            S_VV1: begin
                o_cmd.mop = M_VYVY;
                o_cmd.act = A_ACC;
                n_state   = S_UV0;
            end
            S_UV0: begin
                o_cmd.mop = M_UXVX;
                o_cmd.act = A_VVSUM;
                n_state   = S_UV1;
            end
            S_UV1: begin
                o_cmd.mop     = M_UYVY;
                o_cmd.act     = A_ACC;
                o_cmd.sqrt_go = 1'b1;
                n_state       = S_DOT;
            end
            S_DOT: begin
                o_cmd.act = A_DOTSUM;
                n_state   = S_TSEL;
            end
            S_TSEL: begin
                o_cmd.act = A_TSEL;
                n_state   = i_sts.div_need ? S_DIV : S_OX;
            end
            S_DIV: begin
                o_cmd.act = A_TDIV;
                if (!i_sts.div_busy) n_state = S_OX;
            end
            S_OX: begin
                o_cmd.mop = M_AVXT;
                n_state   = S_OY;
            end
            S_OY: begin
                o_cmd.mop = M_AVYT;
                o_cmd.act = A_PX;
                n_state   = S_PY;
            end
            S_PY: begin
                o_cmd.act = A_PY;
                n_state   = S_DX;
            end
            S_DX: begin
                o_cmd.mop = M_DXDX;
                o_cmd.act = A_DY;
                n_state   = S_DY;
            end
            S_DY: begin
                o_cmd.mop = M_DYDY;
                o_cmd.act = A_ACC;
                n_state   = S_DSUM;
            end
            S_DSUM: begin
                o_cmd.act = A_DSUM;
                n_state   = S_SQW;
            end
            S_SQW: begin
                if (!i_sts.sqrt_busy) begin
                    o_cmd.mop = M_TSEG;
                    n_state   = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.act = A_UPD;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (!i_sts.last) begin
                    o_cmd.act = A_STEP;
                    n_state   = S_IDLE;
                end else if (w_emit) begin
                    o_cmd.act = A_EMIT;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_out_valid = w_emit || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule

// ----- design/polyline_projection_progress.sv -----
// top level: nearest-segment projection and arc length progress along a path
`timescale 1ns / 1ps
//
//  channel   direction  beat when              payload
//  s_axis    in         tvalid & tready        tdata: vertex_x, vertex_y; tlast: last_vertex
//  m_axis    out        tvalid & tready        tuser: valid_res; tdata: progress, remaining
//  cfg       in         valid & ready          index: register, data: robot_x or robot_y
//
//  a first vertex of a path skips the arithmetic and goes straight to the final state;
//  every further vertex is held by the 33-step square root of the squared segment length
//  (the 16-step divider for the projection parameter runs beside it)
//  synchronous active-low reset clears the path state and the robot registers
//  one result register sits on the output: the next path is taken in while a
//  result waits, and only a final vertex stalls until that result is taken
//
module polyline_projection_progress import ppp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // vertex stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_W-1:0]        i_s_axis_tdata,  // vertex_x, vertex_y
    input  logic                   i_s_axis_tlast,
    // result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_W-1:0]       o_m_axis_tdata,  // progress_length, remaining_length
    output logic                   o_m_axis_tuser,  // valid_res
    // register writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [COORD_WIDTH-1:0] i_cfg_data
);
    t_cmd             w_cmd;
    t_sts             w_sts;
    logic [LEN_W-1:0] w_prog, w_rem;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    ppp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    ppp_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_cfg_we           (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_vertex_x         (i_s_axis_tdata[COORD_WIDTH-1:0]),
        .i_vertex_y         (i_s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .i_last_vertex      (i_s_axis_tlast),
        .o_valid_res        (o_m_axis_tuser),
        .o_progress_length  (w_prog),
        .o_remaining_length (w_rem)
    );

    assign o_m_axis_tdata = {w_rem, w_prog};
endmodule

// ----- design/ppp_checker.sv -----
// port-level checks for the polyline projection block, bound to the top level
`timescale 1ns / 1ps
module ppp_checker import ppp_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_axis_tvalid,
    input logic             o_s_axis_tready,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] o_m_axis_tdata,
    input logic             o_m_axis_tuser
);
    // a held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    // a short path reports zero lengths
    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("short path result carries lengths");

    // the block never takes two vertex beats back to back
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("vertex taken back to back");

    // a new result only appears when the input side finished a beat's work
    a_out_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> o_s_axis_tready)
        else $error("result raised while a vertex is still in work");
endmodule

bind polyline_projection_progress ppp_checker u_ppp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// ----- test/tb.sv -----
// testbench for polyline_projection_progress: random vertex paths checked against a scoreboard
`timescale 1ns / 1ps

// scoreboard: keeps its own copy of the path state and predicts each result
class proj_scoreboard;
    logic signed [63:0] robot_x, robot_y;
    logic signed [63:0] prev_x, prev_y;
    int unsigned        verts;
    logic [39:0]        total_len, best_prog;
    logic [63:0]        best_dsq;
    logic [80:0]        want_q[$];   // {valid, remaining, progress}
    int unsigned        errors;

    function new();
        robot_x = 0;
        robot_y = 0;
        errors  = 0;
        clear_path();
    endfunction

    function void clear_path();
        prev_x    = 0;
        prev_y    = 0;
        verts     = 0;
        total_len = 0;
        best_prog = 0;
        best_dsq  = '1;
    endfunction

    function void set_robot(input bit is_y, input logic [31:0] v);
        if (is_y) robot_y = $signed(v);
        else robot_x = $signed(v);
    endfunction

    function logic [39:0] add_sat(input logic [39:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = a + b;
        return (s > 65'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : s[39:0];
    endfunction

    function logic [63:0] root_floor(input logic [127:0] v);
        logic [63:0] r, c;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= v) r = c;
        end
        return r;
    endfunction

    function logic [63:0] abs64(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    // one segment from a to b against the robot position
    function void take_segment(input logic signed [63:0] ax, ay, bx, by, input bit first);
        logic signed [63:0]  vx, vy, ux, uy, px, py, ddx, ddy;
        logic [127:0]        vv, d2, q;
        logic signed [129:0] dot;
        logic [63:0]         t, off, seg, part, dsq;
        vx  = bx - ax;
        vy  = by - ay;
        ux  = robot_x - ax;
        uy  = robot_y - ay;
        vv  = {64'd0, abs64(vx)} * abs64(vx) + {64'd0, abs64(vy)} * abs64(vy);
        dot = 130'(signed'(ux)) * 130'(signed'(vx)) + 130'(signed'(uy)) * 130'(signed'(vy));
        t   = 0;
        if (vv != 0 && dot > 0) begin
            if (dot >= $signed({2'b0, vv})) t = 64'd1 << 16;
            else begin
                q = (dot[127:0] << 16) / vv;
                t = q[63:0];
            end
        end
        q   = {64'd0, abs64(vx)} * t;
        off = q[79:16];
        px  = vx < 0 ? ax - $signed(off) : ax + $signed(off);
        q   = {64'd0, abs64(vy)} * t;
        off = q[79:16];
        py  = vy < 0 ? ay - $signed(off) : ay + $signed(off);
        ddx = robot_x - px;
        ddy = robot_y - py;
        d2  = {64'd0, abs64(ddx)} * abs64(ddx) + {64'd0, abs64(ddy)} * abs64(ddy);
        dsq = d2[127:64] != 0 ? '1 : d2[63:0];
        seg = root_floor(vv);
        if (seg > 64'hFF_FFFF_FFFF) seg = 64'hFF_FFFF_FFFF;
        part = (t * seg) >> 16;
        // strict compare: the earlier segment keeps a tie
        if (first || dsq < best_dsq) begin
            best_dsq  = dsq;
            best_prog = add_sat(total_len, part);
        end
        total_len = add_sat(total_len, seg);
    endfunction

    function void note_vertex(input logic [31:0] x, y, input bit last);
        logic signed [63:0] sx, sy;
        logic [39:0]        rem;
        sx = $signed(x);
        sy = $signed(y);
        if (verts >= 1) take_segment(prev_x, prev_y, sx, sy, verts == 1);
        prev_x = sx;
        prev_y = sy;
        if (verts < 2) verts++;
        if (last) begin
            if (verts >= 2) begin
                rem = best_prog <= total_len ? total_len - best_prog : 40'd0;
                want_q.push_back({1'b1, rem, best_prog});
            end else want_q.push_back('0);
            clear_path();
        end
    endfunction

    function void check_result(input logic user, input logic [79:0] data);
        logic [80:0] w;
        if (want_q.size() == 0) begin
            $error("unexpected result beat user=%0b data=%h", user, data);
            errors++;
            return;
        end
        w = want_q.pop_front();
        if (user !== w[80]) begin
            $error("valid_res exp %0d got %0d", w[80], user);
            errors++;
        end
        if (data[39:0] !== w[39:0]) begin
            $error("progress_length exp %0d got %0d", w[39:0], data[39:0]);
            errors++;
        end
        if (data[79:40] !== w[79:40]) begin
            $error("remaining_length exp %0d got %0d", w[79:40], data[79:40]);
            errors++;
        end
    endfunction
endclass

module tb import ppp_pkg::*;;
    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_W-1:0]        i_s_axis_tdata;
    logic                   i_s_axis_tlast;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_W-1:0]       o_m_axis_tdata;
    logic                   o_m_axis_tuser;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [COORD_WIDTH-1:0] i_cfg_data;

    proj_scoreboard sb = new();
    bit             busy_sides;   // when clear, neither side idles
    int             vert_count;

    polyline_projection_progress dut (.*);

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        if (!busy_sides) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: check each beat, stall at random
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            stall_left      <= 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_result(o_m_axis_tuser, o_m_axis_tdata);
            if (stall_left > 0) begin
                stall_left      <= stall_left - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                stall_left      <= pick_gap();
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_vertex(input logic [31:0] x, y, input bit last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {y, x};
        i_s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_vertex(x, y, last);
        vert_count++;
    endtask

    // wait for the block to drain, then write a register
    task automatic write_robot(input bit is_y, input logic [31:0] v);
        i_s_axis_tvalid <= 1'b0;
        while (sb.want_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= is_y ? CFG_ROBOT_Y : CFG_ROBOT_X;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_robot(is_y, v);
        i_cfg_valid <= 1'b0;
    endtask

    // one random path; shape picks near-robot, full-range, repeated or extreme vertices
    task automatic send_path();
        int          n;
        logic [31:0] x, y, px, py;
        n  = $urandom_range(0, 9) == 0 ? 1 : $urandom_range(2, 8);
        px = 0;
        py = 0;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    x = $urandom();
                    y = $urandom();
                end
                2: begin
                    x = px;
                    y = py;
                end
                3: begin
                    x = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    y = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                end
                default: begin
                    x = sb.robot_x[31:0] + 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
                    y = sb.robot_y[31:0] + 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
                end
            endcase
            send_vertex(x, y, i == n - 1);
            px = x;
            py = y;
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tlast  = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_ROBOT_X;
        i_cfg_data      = '0;
        busy_sides      = 1'b0;
        vert_count      = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, robot at origin
        send_vertex(32'h0001_0000, 32'h0, 1'b1);                 // lone vertex path
        send_vertex(32'hFFFF_0000, 32'h0, 1'b0);                 // robot inside segment
        send_vertex(32'h0001_0000, 32'h0, 1'b1);
        send_vertex(32'h0002_0000, 32'h0002_0000, 1'b0);         // zero-length segment
        send_vertex(32'h0002_0000, 32'h0002_0000, 1'b1);
        send_vertex(32'h0001_0000, 32'h0, 1'b0);                 // robot before start
        send_vertex(32'h0005_0000, 32'h0, 1'b1);
        send_vertex(32'h0, 32'hFFFB_0000, 1'b0);                 // robot past end
        send_vertex(32'h0, 32'hFFFF_0000, 1'b1);
        send_vertex(32'hFFFF_0000, 32'h0001_0000, 1'b0);         // equal distance, first wins
        send_vertex(32'h0001_0000, 32'h0001_0000, 1'b0);
        send_vertex(32'h0001_0000, 32'hFFFF_0000, 1'b0);
        send_vertex(32'hFFFF_0000, 32'hFFFF_0000, 1'b1);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);         // extremes, long lengths
        send_vertex(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        write_robot(1'b0, 32'h8000_0000);
        write_robot(1'b1, 32'h8000_0000);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);         // far segments saturate distance
        send_vertex(32'h7FFF_0000, 32'h7FFF_FFFF, 1'b0);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_0000, 1'b1);

        // random phases across several robot positions
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_robot(1'b0, 32'h0); write_robot(1'b1, 32'h0); end
                1: begin write_robot(1'b0, 32'h7FFF_FFFF); write_robot(1'b1, 32'h8000_0000); end
                2: begin write_robot(1'b0, 32'h8000_0000); write_robot(1'b1, 32'h7FFF_FFFF); end
                default: begin
                    write_robot(1'b0, $urandom());
                    write_robot(1'b1, $urandom());
                end
            endcase
            busy_sides = (ph != 2);
            while (vert_count < 20 + 250 * (ph + 1)) send_path();
        end
        i_s_axis_tvalid <= 1'b0;

        while (sb.want_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0) $display("tb: PASS");
        else $display("tb: FAIL");
        $finish;
    end

    initial begin
        #50ms;
        $display("tb: FAIL");
        $finish;
    end
endmodule

// ----- sim.f -----
design/ppp_pkg.sv
design/ppp_div.sv
design/ppp_sqrt.sv
design/ppp_dp.sv
design/ppp_ctrl.sv
design/polyline_projection_progress.sv
design/ppp_checker.sv
test/tb.sv
